// ===== rtl/core/ortf_pkg.sv =====
// Shared package for the overwrite-oldest trace ring FIFO.
// Holds the command codes, field widths and the controller-to-datapath command struct.
// No dependencies.
package ortf_pkg;

  localparam int unsigned DEPTH_DEF = 1024;

  // Field widths of the transaction ports
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned REQ_W   = 8;

  // Operation codes carried by in_cmd
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Saturation limit of the per-request valid byte counter
  localparam logic [REQ_W-1:0] REQ_MAX = '1;

  // Controller commands to the datapath
  typedef struct packed {
    logic wr_item;    // accepted write: store byte, update pointers, load result
    logic rd_item;    // accepted read: issue store read, update pointers, load result fields
    logic byte_load;  // store read data is back: load read byte into the result register
  } ortf_cmd_t;

endpackage

// ===== rtl/core/ortf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the trace byte store. No dependencies.
module ortf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/ortf_ctrl.sv =====
// Transaction controller for the trace ring FIFO: handshakes and sequencing.
// Depends on ortf_pkg; drives the ortf_dp command struct.
module ortf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_cmd,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ortf_pkg::ortf_cmd_t   cmd
);
  import ortf_pkg::*;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_RDWAIT = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;
  logic accept;

  // Output slot is free when empty or being drained this cycle
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_WRITE) begin
            cmd.wr_item   = 1'b1;
            out_valid_nxt = 1'b1;
          end else begin
            cmd.rd_item = 1'b1;
            state_nxt   = ST_RDWAIT;
          end
        end
      end
      ST_RDWAIT: begin
        cmd.byte_load = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // No new transaction while a read waits on the store
  a_no_accept_in_rdwait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RDWAIT) |-> !in_ready)
    else $error("input taken while store read pending");

  // A taken read passes the read wait state and then presents its result
  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_item |=> ##1 out_valid_r)
    else $error("read result not presented on time");

  // Result slot is empty whenever the read data comes back
  a_slot_free_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.byte_load |-> !out_valid_r)
    else $error("read data would overwrite a pending result");

endmodule

// ===== rtl/core/ortf_dp.sv =====
// Datapath for the trace ring FIFO: pointers, fill count, request counter,
// byte store and result register. Depends on ortf_pkg and ortf_ram.
module ortf_dp #(
  parameter int unsigned DEPTH = ortf_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ortf_pkg::ortf_cmd_t           cmd,
  input  logic [ortf_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic                          in_last_of_run,
  output logic [ortf_pkg::BYTE_W-1:0]   out_read_byte,
  output logic                          out_byte_valid,
  output logic [ortf_pkg::REQ_W-1:0]    out_request_valid_total,
  output logic [ortf_pkg::COUNT_W-1:0]  out_fill_count,
  output logic [ortf_pkg::COUNT_W-1:0]  out_free_space,
  output logic                          out_overwrote_oldest
);
  import ortf_pkg::*;

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     held_r, held_nxt;
  logic [REQ_W-1:0]  req_cnt_r, req_cnt_nxt;
  logic [REQ_W-1:0]  req_total;
  logic              full, empty;
  logic [BYTE_W-1:0] ram_rdata;

  // Result register (payload, no reset)
  logic [BYTE_W-1:0] rbyte_r, rbyte_nxt;
  logic              bvalid_r, bvalid_nxt;
  logic [REQ_W-1:0]  total_r, total_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic              over_r, over_nxt;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  assign full  = (held_r == CNT_FULL);
  assign empty = (held_r == '0);

  always_comb begin
    wr_ptr_nxt  = wr_ptr_r;
    rd_ptr_nxt  = rd_ptr_r;
    held_nxt    = held_r;
    req_cnt_nxt = req_cnt_r;
    req_total   = req_cnt_r;
    if (cmd.wr_item) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_r);
      if (full) begin
        rd_ptr_nxt = ptr_inc(rd_ptr_r);
      end else begin
        held_nxt = held_r + 1'b1;
      end
    end else if (cmd.rd_item) begin
      if (!empty) begin
        rd_ptr_nxt = ptr_inc(rd_ptr_r);
        held_nxt   = held_r - 1'b1;
        if (req_cnt_r != REQ_MAX) begin
          req_total = req_cnt_r + 1'b1;
        end
      end
      req_cnt_nxt = in_last_of_run ? '0 : req_total;
    end
  end

  always_comb begin
    rbyte_nxt  = rbyte_r;
    bvalid_nxt = bvalid_r;
    total_nxt  = total_r;
    fill_nxt   = fill_r;
    over_nxt   = over_r;
    if (cmd.wr_item) begin
      rbyte_nxt  = '0;
      bvalid_nxt = 1'b0;
      total_nxt  = '0;
      fill_nxt   = held_nxt;
      over_nxt   = full;
    end else if (cmd.rd_item) begin
      bvalid_nxt = !empty;
      total_nxt  = req_total;
      fill_nxt   = held_nxt;
      over_nxt   = 1'b0;
    end else if (cmd.byte_load) begin
      rbyte_nxt = bvalid_r ? ram_rdata : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      held_r    <= '0;
      req_cnt_r <= '0;
    end else begin
      wr_ptr_r  <= wr_ptr_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      held_r    <= held_nxt;
      req_cnt_r <= req_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rbyte_r  <= rbyte_nxt;
    bvalid_r <= bvalid_nxt;
    total_r  <= total_nxt;
    fill_r   <= fill_nxt;
    over_r   <= over_nxt;
  end

  ortf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_item),
    .wr_addr (wr_ptr_r),
    .wr_data (in_data_byte),
    .rd_en   (cmd.rd_item),
    .rd_addr (rd_ptr_r),
    .rd_data (ram_rdata)
  );

  assign out_read_byte           = rbyte_r;
  assign out_byte_valid          = bvalid_r;
  assign out_request_valid_total = total_r;
  assign out_fill_count          = COUNT_W'(fill_r);
  assign out_free_space          = COUNT_W'(CNT_FULL - fill_r);
  assign out_overwrote_oldest    = over_r;

  // Fill count never passes the ring depth
  a_held_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CNT_FULL)
    else $error("fill count beyond depth");

  // A write into a full ring keeps it full and moves the read pointer
  a_overwrite_keeps_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_item && full) |=> (full && rd_ptr_r == ptr_inc($past(rd_ptr_r))))
    else $error("overwrite did not drop the oldest byte");

  // Pointers meet whenever the ring is empty
  a_ptr_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty ring with pointers apart");

endmodule

// ===== rtl/core/overwrite_ring_trace_fifo.sv =====
// Overwrite-oldest byte ring FIFO for trace capture. Each input transaction is
// one byte access: in_cmd selects write (store in_data_byte) or read (return
// the oldest byte). A write into a full ring overwrites the oldest byte and
// flags out_overwrote_oldest; a read of an empty ring returns zero with
// out_byte_valid low. in_last_of_run closes a read request, and each read result
// reports the valid bytes delivered so far in that request (saturating at 255).
// Every result carries the fill count and free space after the transaction.
// A write's result is presented in the cycle after acceptance; a read first
// passes the read wait state, as the byte store has a registered read port.
// One transaction is in flight at a time: one write per cycle while out_ready
// is high, no input while a read waits. The result sits in an output register,
// so the next write is taken in the same cycle the previous result is drained.
// Depends on ortf_pkg, ortf_ctrl, ortf_dp, ortf_ram.
module overwrite_ring_trace_fifo #(
  parameter int unsigned DEPTH = ortf_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input transaction channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [ortf_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic                          in_last_of_run,
  // Result transaction channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ortf_pkg::BYTE_W-1:0]   out_read_byte,
  output logic                          out_byte_valid,
  output logic [ortf_pkg::REQ_W-1:0]    out_request_valid_total,
  output logic [ortf_pkg::COUNT_W-1:0]  out_fill_count,
  output logic [ortf_pkg::COUNT_W-1:0]  out_free_space,
  output logic                          out_overwrote_oldest
);
  import ortf_pkg::*;

  ortf_cmd_t cmd;

  // Sequencing: handshakes, read wait state, result-valid flag
  ortf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Pointers, counts, byte store and result register
  ortf_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cmd                     (cmd),
    .in_data_byte            (in_data_byte),
    .in_last_of_run          (in_last_of_run),
    .out_read_byte           (out_read_byte),
    .out_byte_valid          (out_byte_valid),
    .out_request_valid_total (out_request_valid_total),
    .out_fill_count          (out_fill_count),
    .out_free_space          (out_free_space),
    .out_overwrote_oldest    (out_overwrote_oldest)
  );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for overwrite_ring_trace_fifo: random byte writes and reads
// against a mirror of the ring, with idling and back-pressure on both channels.
// Depends on ortf_pkg and the overwrite_ring_trace_fifo RTL.

typedef struct packed {
  logic [ortf_pkg::BYTE_W-1:0]  read_byte;
  logic                         byte_valid;
  logic [ortf_pkg::REQ_W-1:0]   req_total;
  logic [ortf_pkg::COUNT_W-1:0] fill;
  logic [ortf_pkg::COUNT_W-1:0] free_space;
  logic                         overwrote;
} ring_result_t;

// Mirror of the ring: predicts one result per accepted transaction and checks
// the DUT results against them in order.
class trace_ring_scoreboard;
  bit [ortf_pkg::BYTE_W-1:0] ring_bytes [ortf_pkg::DEPTH_DEF];
  int unsigned wr_ptr, rd_ptr, held;
  bit [ortf_pkg::REQ_W-1:0] req_count;
  ring_result_t due_results [$];
  int unsigned errors, checked;
  int unsigned n_writes, n_reads, n_overwrites, n_empty_reads, n_saturated;

  function int unsigned ring_next(int unsigned p);
    return (p + 1 >= ortf_pkg::DEPTH_DEF) ? 0 : p + 1;
  endfunction

  function void note_input(logic cmd, logic [ortf_pkg::BYTE_W-1:0] data, logic last);
    ring_result_t want;
    int unsigned  free_cnt;
    want = '0;
    if (cmd == ortf_pkg::CMD_WRITE) begin
      n_writes++;
      ring_bytes[wr_ptr] = data;
      wr_ptr = ring_next(wr_ptr);
      if (held < ortf_pkg::DEPTH_DEF) begin
        held++;
      end else begin
        // full ring: oldest byte is dropped
        rd_ptr = ring_next(rd_ptr);
        want.overwrote = 1'b1;
        n_overwrites++;
      end
    end else begin
      n_reads++;
      if (held != 0) begin
        want.read_byte  = ring_bytes[rd_ptr];
        want.byte_valid = 1'b1;
        rd_ptr = ring_next(rd_ptr);
        held--;
        if (req_count != ortf_pkg::REQ_MAX) req_count++;
        else n_saturated++;
      end else begin
        n_empty_reads++;
      end
      want.req_total = req_count;
      if (last) req_count = '0;
    end
    free_cnt        = ortf_pkg::DEPTH_DEF - held;
    want.fill       = held[ortf_pkg::COUNT_W-1:0];
    want.free_space = free_cnt[ortf_pkg::COUNT_W-1:0];
    due_results.push_back(want);
  endfunction

  function void check_field(string name, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      errors++;
      $display("%0t: mismatch on %s, expected %0d, got %0d", $time, name, want_v, got_v);
    end
  endfunction

  function void check_result(ring_result_t got);
    ring_result_t want;
    if (due_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, got %h", $time, got);
      return;
    end
    want = due_results.pop_front();
    checked++;
    check_field("read_byte", want.read_byte, got.read_byte);
    check_field("byte_valid", want.byte_valid, got.byte_valid);
    check_field("request_valid_total", want.req_total, got.req_total);
    check_field("fill_count", want.fill, got.fill);
    check_field("free_space", want.free_space, got.free_space);
    check_field("overwrote_oldest", want.overwrote, got.overwrote);
  endfunction
endclass

module tb_top;
  import ortf_pkg::*;

  localparam int unsigned RING_DEPTH  = DEPTH_DEF;
  // Slowest run: ~800 transactions, each with the longest send gap, result
  // stall and read wait state, plus one long hold-off.
  localparam int unsigned LIMIT_CYCLES = 100000;
  localparam int unsigned HOLD_CYCLES  = 300;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_cmd = CMD_WRITE;
  logic [BYTE_W-1:0]   in_data_byte = '0;
  logic                in_last_of_run = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [BYTE_W-1:0]   out_read_byte;
  logic                out_byte_valid;
  logic [REQ_W-1:0]    out_request_valid_total;
  logic [COUNT_W-1:0]  out_fill_count;
  logic [COUNT_W-1:0]  out_free_space;
  logic                out_overwrote_oldest;

  trace_ring_scoreboard sb = new();

  // Idling is switched off for the closing phase.
  bit          idle_on = 1'b1;
  // Set once by the stimulus to ask the result side for a long hold-off.
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned sink_stall = 0;
  int unsigned cycle_count = 0;
  ring_result_t seen_res;

  overwrite_ring_trace_fifo #(
    .DEPTH(RING_DEPTH)
  ) dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_cmd                  (in_cmd),
    .in_data_byte            (in_data_byte),
    .in_last_of_run          (in_last_of_run),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_read_byte           (out_read_byte),
    .out_byte_valid          (out_byte_valid),
    .out_request_valid_total (out_request_valid_total),
    .out_fill_count          (out_fill_count),
    .out_free_space          (out_free_space),
    .out_overwrote_oldest    (out_overwrote_oldest)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.due_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // Result side. Values are sampled at the edge before any NBA lands, so the
  // handshake seen here is the one the DUT saw. out_ready for the next cycle
  // is chosen afterward: long hold-off, random stall burst, or ready.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_res.read_byte  = out_read_byte;
      seen_res.byte_valid = out_byte_valid;
      seen_res.req_total  = out_request_valid_total;
      seen_res.fill       = out_fill_count;
      seen_res.free_space = out_free_space;
      seen_res.overwrote  = out_overwrote_oldest;
      sb.check_result(seen_res);
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      // sender keeps offering during this, so the DUT must stall its input
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (sink_stall != 0) begin
      sink_stall--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      sink_stall = $urandom_range(1, 11) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Offer one transaction and wait for its handshake. Called at a rising edge;
  // valid stays high between back-to-back transactions.
  task automatic offer_byte_op(input logic cmd, input logic [BYTE_W-1:0] data,
                               input logic last);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_data_byte   <= data;
    in_last_of_run <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(cmd, data, last);
  endtask

  // Random mix of writes and reads; last flags on both kinds.
  task automatic run_mixed(input int unsigned count, input int unsigned wr_pct,
                           input int unsigned hold_at);
    logic cmd;
    for (int unsigned i = 0; i < count; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      cmd = ($urandom_range(0, 99) < wr_pct) ? CMD_WRITE : CMD_READ;
      offer_byte_op(cmd, BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    end
  endtask

  // Build the fill level up to a target with a few reads sprinkled in, then
  // keep writing for a short while.
  task automatic run_flood(input int unsigned target);
    int unsigned extra;
    logic cmd;
    extra = $urandom_range(5, 15);
    while (sb.held < target) begin
      cmd = ($urandom_range(0, 19) == 0) ? CMD_READ : CMD_WRITE;
      offer_byte_op(cmd, BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
    end
    repeat (extra) offer_byte_op(CMD_WRITE, BYTE_W'($urandom_range(0, 255)),
                                 $urandom_range(0, 3) == 0);
  endtask

  // Empty the ring: one request long enough to saturate the request count,
  // then requests of random length, then reads on the empty ring.
  task automatic run_drain();
    for (int unsigned i = 0; i < 280; i++)
      offer_byte_op(CMD_READ, BYTE_W'($urandom_range(0, 255)), i == 279);
    while (sb.held != 0)
      offer_byte_op(CMD_READ, BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
    for (int unsigned i = 0; i < 3; i++)
      offer_byte_op(CMD_READ, BYTE_W'($urandom_range(0, 255)), i == 2);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty reads, data extremes, last flag on a write, writes
    // inside a read request, empty reads that still report the request total.
    offer_byte_op(CMD_READ,  8'h00, 1'b0);
    offer_byte_op(CMD_READ,  8'hFF, 1'b1);
    offer_byte_op(CMD_WRITE, 8'h00, 1'b0);
    offer_byte_op(CMD_WRITE, 8'hFF, 1'b1);
    offer_byte_op(CMD_WRITE, 8'hA5, 1'b0);
    offer_byte_op(CMD_READ,  8'h00, 1'b0);
    offer_byte_op(CMD_WRITE, 8'h5A, 1'b1);
    offer_byte_op(CMD_READ,  8'h00, 1'b0);
    offer_byte_op(CMD_READ,  8'h00, 1'b1);
    offer_byte_op(CMD_READ,  8'hFF, 1'b0);
    offer_byte_op(CMD_READ,  8'h00, 1'b0);
    offer_byte_op(CMD_READ,  8'h00, 1'b1);
    offer_byte_op(CMD_READ,  8'h55, 1'b1);
    offer_byte_op(CMD_WRITE, 8'h55, 1'b0);
    offer_byte_op(CMD_WRITE, 8'hAA, 1'b0);
    offer_byte_op(CMD_READ,  8'hAA, 1'b1);

    // Random phases: low fill with a long result hold-off, build the fill
    // level up, a short churn, then drain to empty with a saturating request.
    run_mixed(120, 60, 50);
    run_flood(280);
    run_mixed(30, 50, '1);
    run_drain();

    // Closing phase runs with no idling on either side.
    idle_on = 1'b0;
    run_mixed(40, 55, '1);
    in_valid <= 1'b0;

    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d writes (%0d overwrote the oldest byte) and %0d reads (%0d on empty ring)",
             sb.n_writes, sb.n_overwrites, sb.n_reads, sb.n_empty_reads);
    $display("%0d results checked, %0d reads at saturated request count, %0d errors",
             sb.checked, sb.n_saturated, sb.errors);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
